// ===== sv/wdwm_pkg.sv =====
`timescale 1ns / 1ps

package wdwm_pkg;

    localparam int ROWS_DEF        = 20;
    localparam int DIRECTIONS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 12;

    localparam int DIR_W    = 4;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int TOTAL_W  = 17;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(30);
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

    // Per-transfer command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             upd;
        logic             advance;
        logic [DIR_W-1:0] dir;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_HOLD = 4'b1000
    } t_state;

endpackage

// ===== sv/wind_direction_window_mode_top.sv =====
`timescale 1ns / 1ps

// Wind direction mode over a sliding window of histogram rows.
// Input channel: i_valid / o_ready carry a direction bin and a timestamp in
// seconds. Output channel: o_valid / i_ready carry the most frequent direction
// over the window (lowest bin on ties) and its total, saturated to 17 bits.
// Exactly one result follows every input transfer, in order.
// Configuration: i_cfg_we writes i_cfg_data into the row period at once.
// One sample is handled at a time. After an input transfer there is an
// update state (ring advance and count increment), then a scan state while
// the running maximum walks the chain of direction cells one cell per
// cycle, then a hold state that loads the output register once the
// receiver has room.
// o_ready returns high together with o_valid, so the next sample
// can be taken while that result still waits. If the receiver stalls with a
// result already held, the next result waits inside the block and o_ready
// stays low until the held result is taken.
// Reset clears all counts and the row start time, and sets the row
// period to 30 seconds.
module wind_direction_window_mode_top #(
    parameter int ROWS        = wdwm_pkg::ROWS_DEF,
    parameter int DIRECTIONS  = wdwm_pkg::DIRECTIONS_DEF,
    parameter int COUNT_WIDTH = wdwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wdwm_pkg::PERIOD_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wdwm_pkg::DIR_W-1:0]    i_direction_bin,
    input  logic [wdwm_pkg::TIME_W-1:0]   i_time_seconds,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [wdwm_pkg::DIR_W-1:0]    o_mode_direction,
    output logic [wdwm_pkg::TOTAL_W-1:0]  o_mode_total
);

    localparam int TOT_W = COUNT_WIDTH + $clog2(ROWS);
    localparam int CMP_W = (TOT_W > wdwm_pkg::TOTAL_W) ? TOT_W : wdwm_pkg::TOTAL_W;
    localparam int SW    = $clog2(DIRECTIONS);

    wdwm_pkg::t_state r_state, n_state;
    logic [SW-1:0]                   r_scan_cnt;
    logic [wdwm_pkg::PERIOD_W-1:0]   r_period;
    logic [wdwm_pkg::TIME_W-1:0]     r_row_start;
    logic [wdwm_pkg::DIR_W-1:0]      r_dir;
    logic [wdwm_pkg::TIME_W-1:0]     r_time;
    logic                            r_o_valid;
    logic [wdwm_pkg::DIR_W-1:0]      r_o_dir;
    logic [wdwm_pkg::TOTAL_W-1:0]    r_o_total;

    logic [wdwm_pkg::TIME_W-1:0]     w_elapsed;
    logic                            w_advance;
    logic                            w_in_xfer;
    logic                            w_out_free;
    logic                            w_load;
    logic [CMP_W-1:0]                w_total_ext;
    logic [wdwm_pkg::TOTAL_W-1:0]    w_total_sat;
    wdwm_pkg::t_cell_ctl             w_ctl;

    logic [wdwm_pkg::DIR_W-1:0] w_chain_dir   [DIRECTIONS+1];
    logic [TOT_W-1:0]           w_chain_total [DIRECTIONS+1];

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_load     = (r_state == wdwm_pkg::ST_HOLD) && w_out_free;

    assign w_elapsed = r_time - r_row_start;
    assign w_advance = (w_elapsed >= wdwm_pkg::TIME_W'(r_period));

    assign w_ctl.upd     = (r_state == wdwm_pkg::ST_UPD);
    assign w_ctl.advance = w_advance;
    assign w_ctl.dir     = r_dir;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wdwm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = wdwm_pkg::ST_UPD;
                end
            end
            wdwm_pkg::ST_UPD: begin
                n_state = wdwm_pkg::ST_SCAN;
            end
            wdwm_pkg::ST_SCAN: begin
                if (r_scan_cnt == SW'(DIRECTIONS - 1)) begin
                    n_state = wdwm_pkg::ST_HOLD;
                end
            end
            wdwm_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    n_state = wdwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wdwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wdwm_pkg::ST_IDLE;
            r_scan_cnt  <= '0;
            r_period    <= wdwm_pkg::PERIOD_RESET;
            r_row_start <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (r_state == wdwm_pkg::ST_SCAN) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end else begin
                r_scan_cnt <= '0;
            end
            if (w_ctl.upd && w_advance) begin
                r_row_start <= r_time;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_dir  <= i_direction_bin;
            r_time <= i_time_seconds;
        end
        if (w_load) begin
            r_o_dir   <= w_chain_dir[DIRECTIONS];
            r_o_total <= w_total_sat;
        end
    end

    // The choice of bin uses the full total; only the reported value clips.
    assign w_total_ext = CMP_W'(w_chain_total[DIRECTIONS]);
    assign w_total_sat = (w_total_ext > CMP_W'(wdwm_pkg::TOTAL_MAX))
                         ? wdwm_pkg::TOTAL_MAX : w_total_ext[wdwm_pkg::TOTAL_W-1:0];

    assign w_chain_dir[0]   = '0;
    assign w_chain_total[0] = '0;

    for (genvar d = 0; d < DIRECTIONS; d++) begin : g_cell
        wdwm_cell #(
            .ROWS        (ROWS),
            .COUNT_WIDTH (COUNT_WIDTH),
            .TOT_W       (TOT_W),
            .IDX         (d)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_best_dir   (w_chain_dir[d]),
            .i_best_total (w_chain_total[d]),
            .o_best_dir   (w_chain_dir[d+1]),
            .o_best_total (w_chain_total[d+1])
        );
    end

    assign o_ready          = (r_state == wdwm_pkg::ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_mode_direction = r_o_dir;
    assign o_mode_total     = r_o_total;

endmodule

// ===== sv/wdwm_cell.sv =====
`timescale 1ns / 1ps

module wdwm_cell #(
    parameter int ROWS        = wdwm_pkg::ROWS_DEF,
    parameter int COUNT_WIDTH = wdwm_pkg::COUNT_WIDTH_DEF,
    parameter int TOT_W       = COUNT_WIDTH + $clog2(ROWS),
    parameter int IDX         = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wdwm_pkg::t_cell_ctl        i_ctl,
    input  logic [wdwm_pkg::DIR_W-1:0] i_best_dir,
    input  logic [TOT_W-1:0]           i_best_total,
    output logic [wdwm_pkg::DIR_W-1:0] o_best_dir,
    output logic [TOT_W-1:0]           o_best_total
);

    // Ring of this direction's counts: entry 0 is the current row and the
    // last entry is the oldest row, which drops out when the ring advances.
    logic [COUNT_WIDTH-1:0] r_ring [ROWS];
    logic [TOT_W-1:0]       r_other;
    logic [wdwm_pkg::DIR_W-1:0] r_best_dir;
    logic [TOT_W-1:0]       r_best_total;

    logic                   w_hit;
    logic [COUNT_WIDTH-1:0] w_head_inc;
    logic [TOT_W-1:0]       w_own_total;
    logic                   w_take_own;

    assign w_hit      = (i_ctl.dir == wdwm_pkg::DIR_W'(IDX));
    assign w_head_inc = (r_ring[0] == {COUNT_WIDTH{1'b1}}) ? r_ring[0]
                                                          : r_ring[0] + 1'b1;
    assign w_own_total = TOT_W'(r_ring[0]) + r_other;
    assign w_take_own  = (IDX == 0) || (w_own_total > i_best_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROWS; k++) begin
                r_ring[k] <= '0;
            end
            r_other <= '0;
        end else if (i_ctl.upd) begin
            if (i_ctl.advance) begin
                // Rows other than the new current row: everything except the
                // oldest row, which drops out of the window.
                r_other <= r_other + TOT_W'(r_ring[0]) - TOT_W'(r_ring[ROWS-1]);
                for (int k = 1; k < ROWS; k++) begin
                    r_ring[k] <= r_ring[k-1];
                end
                r_ring[0] <= w_hit ? COUNT_WIDTH'(1) : '0;
            end else if (w_hit) begin
                r_ring[0] <= w_head_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_own) begin
            r_best_dir   <= wdwm_pkg::DIR_W'(IDX);
            r_best_total <= w_own_total;
        end else begin
            r_best_dir   <= i_best_dir;
            r_best_total <= i_best_total;
        end
    end

    assign o_best_dir   = r_best_dir;
    assign o_best_total = r_best_total;

endmodule

// ===== sv/wdwm_checker.sv =====
`timescale 1ns / 1ps

module wdwm_checker #(
    parameter int DIRECTIONS = wdwm_pkg::DIRECTIONS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [wdwm_pkg::DIR_W-1:0]   o_mode_direction,
    input logic [wdwm_pkg::TOTAL_W-1:0] o_mode_total
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mode_direction)
                                && $stable(o_mode_total))
        else $error("result changed while stalled");

    // Only one sample is in work at a time, so o_ready drops after an input transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready ##1 !o_ready)
        else $error("input taken while a sample was in work");

    // A zero total means every bin is empty, so the lowest bin wins.
    a_empty_bin0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_mode_total == '0) |-> (o_mode_direction == '0))
        else $error("empty window reported a bin other than zero");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mode_direction < wdwm_pkg::DIR_W'(DIRECTIONS - 1))
                    || (o_mode_direction == wdwm_pkg::DIR_W'(DIRECTIONS - 1)))
        else $error("reported direction beyond the last bin");

endmodule

bind wind_direction_window_mode_top wdwm_checker #(
    .DIRECTIONS (DIRECTIONS)
) u_wdwm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_mode_direction (o_mode_direction),
    .o_mode_total     (o_mode_total)
);
